[rtl/e2c_pkg.sv]
// shared constants, types and helpers for the epoch seconds to calendar pipeline
package e2c_pkg;

    // width of the signed seconds count that is used
    localparam int SECONDS_BITS = 40;
    localparam int IN_W         = ((SECONDS_BITS + 7) / 8) * 8;
    localparam int OUT_W        = 56;

    // register stages from input transfer to output register
    localparam int PIPE_DEPTH   = 11;
    localparam int TOD_DELAY    = PIPE_DEPTH - 7;

    localparam int SOD_W        = 17;

    // biased floor(secs / 128), day number plus bias, biased day of era shift
    localparam int UW  = SECONDS_BITS - 6;
    localparam int UM  = UW + 1;
    localparam int QW  = UW - 9;
    localparam int ZW  = QW + 2;
    localparam int ZM  = ZW + 1;
    localparam int ZP  = 2 * ZW + 1;
    localparam int EW  = ZW - 17;

    // floor(u / 675) by reciprocal, split into two partial products
    localparam int S675 = UW + 10;
    localparam logic [UW:0] M675 = UM'(((64'd1 << S675) + 64'd674) / 64'd675);
    localparam int MLW  = UM / 2;
    localparam int MHW  = UM - MLW;
    localparam int PLW  = UW + MLW;
    localparam int PHW  = UW + MHW;
    localparam int SUMW = 2 * UW + 1;

    localparam logic [UW-1:0] BIAS675 = UW'(64'd675 << (SECONDS_BITS - 17));

    // day number to march based day count with whole eras added to stay positive
    localparam logic [ZW-1:0] ZZ_OFFSET = ZW'(64'd719468
                                              + (64'd146097 << (SECONDS_BITS - 34))
                                              - (64'd1 << (SECONDS_BITS - 17)));

    localparam int S_ERA = ZW + 18;
    localparam logic [ZW:0] M_ERA = ZM'(((64'd1 << S_ERA) + 64'd146096) / 64'd146097);
    localparam int S7 = ZW + 3;
    localparam logic [ZW:0] M7 = ZM'(((64'd1 << S7) + 64'd6) / 64'd7);

    // removes the era bias and the 1900 base from the year
    localparam logic [15:0] YEAR_OFFSET = 16'((64'd400 << (SECONDS_BITS - 34)) + 64'd1900);

    // fixed width reciprocals
    localparam logic [17:0] M60_SOD  = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
    localparam logic [11:0] M60_MIN  = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
    localparam logic [18:0] M1460    = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M36524   = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] M365     = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  M100     = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] M153     = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    localparam logic [17:0] LAST_DAY_OF_ERA = 18'd146096;
    localparam logic [3:0]  FIRST_JAN_MP    = 4'd10;

    typedef struct packed {
        logic [ZW-1:0]    zz;
        logic [SOD_W-1:0] sod;
    } e2c_day_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } e2c_tod_t;

    typedef struct packed {
        logic [4:0]  dom;
        logic [3:0]  month;
        logic [8:0]  yday;
        logic [15:0] years;
        logic [2:0]  weekday;
    } e2c_date_t;

    // day of the march based year on which each month starts
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

[rtl/e2c_day_split.sv]
// stages one to four: floor split of seconds into day count and second of day
module e2c_day_split
    import e2c_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [SECONDS_BITS-1:0] epoch_seconds,
    output e2c_day_t                day
);

    logic [UW-1:0]   u1_reg, u1_next;
    logic [6:0]      r1_reg;
    logic [PLW-1:0]  pl2_reg, pl2_next;
    logic [PHW-1:0]  ph2_reg, ph2_next;
    logic [9:0]      u2_reg;
    logic [6:0]      r2_reg;
    logic [QW-1:0]   q3_reg, q3_next;
    logic [9:0]      u3_reg;
    logic [6:0]      r3_reg;
    e2c_day_t        day_reg, day_next;

    logic [SUMW-1:0] sum;
    logic [19:0]     qm;
    logic [9:0]      rem;

    always_comb
    begin
        // arithmetic shift by 128, then bias so the divide by 675 stays unsigned
        u1_next  = {epoch_seconds[SECONDS_BITS-1], epoch_seconds[SECONDS_BITS-1:7]}
                   + BIAS675;
        pl2_next = PLW'(u1_reg) * PLW'(M675[MLW-1:0]);
        ph2_next = PHW'(u1_reg) * PHW'(M675[UW:MLW]);
        sum      = SUMW'({ph2_reg, {MLW{1'b0}}}) + SUMW'(pl2_reg);
        q3_next  = sum[S675 +: QW];
        // remainder is below 675, so ten bits carry it
        qm       = 20'(q3_reg[9:0]) * 20'd675;
        rem      = u3_reg - qm[9:0];
        day_next.sod = {rem, r3_reg};
        day_next.zz  = ZW'(q3_reg) + ZZ_OFFSET;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg  <= u1_next;
            r1_reg  <= epoch_seconds[6:0];
            pl2_reg <= pl2_next;
            ph2_reg <= ph2_next;
            u2_reg  <= u1_reg[9:0];
            r2_reg  <= r1_reg;
            q3_reg  <= q3_next;
            u3_reg  <= u2_reg;
            r3_reg  <= r2_reg;
            day_reg <= day_next;
        end
    end

    assign day = day_reg;

endmodule

[rtl/e2c_tod.sv]
// stages five to eleven: hour, minute and second from the second of day
module e2c_tod
    import e2c_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [SOD_W-1:0] sod,
    output e2c_tod_t         tod
);

    logic [10:0] mins5_reg, mins5_next;
    logic [5:0]  sod5_reg;
    logic [5:0]  sec6_reg, sec6_next;
    logic [4:0]  hour6_reg, hour6_next;
    logic [5:0]  min6_reg;
    e2c_tod_t    tod7_reg, tod7_next;
    e2c_tod_t    tod_pipe_reg [TOD_DELAY];

    logic [34:0] p_sod;
    logic [11:0] mm;
    logic [22:0] p_min;
    logic [10:0] hm;

    always_comb
    begin
        p_sod      = 35'(sod) * 35'(M60_SOD);
        mins5_next = p_sod[23 +: 11];
        mm         = 12'(mins5_reg[5:0]) * 12'd60;
        sec6_next  = sod5_reg - mm[5:0];
        p_min      = 23'(mins5_reg) * 23'(M60_MIN);
        hour6_next = p_min[17 +: 5];
        hm         = 11'(hour6_reg) * 11'd60;
        tod7_next.hour   = hour6_reg;
        tod7_next.minute = min6_reg - hm[5:0];
        tod7_next.second = sec6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mins5_reg <= mins5_next;
            sod5_reg  <= sod[5:0];
            sec6_reg  <= sec6_next;
            hour6_reg <= hour6_next;
            min6_reg  <= mins5_reg[5:0];
            tod7_reg  <= tod7_next;
            tod_pipe_reg[0] <= tod7_reg;
            for (int i = 1; i < TOD_DELAY; i++)
            begin
                tod_pipe_reg[i] <= tod_pipe_reg[i-1];
            end
        end
    end

    assign tod = tod_pipe_reg[TOD_DELAY-1];

endmodule

[rtl/e2c_civil.sv]
// stages five to eleven: civil date and weekday from the biased day count
module e2c_civil
    import e2c_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  e2c_day_t  day,
    output e2c_date_t date
);

    // stage five
    logic [EW-1:0] era5_reg;
    logic [2:0]    wq5_reg;
    logic [17:0]   zz5_reg;
    // stage six
    logic [17:0]   doe6_reg, doe6_next;
    logic [EW-1:0] era6_reg;
    logic [2:0]    wd6_reg, wd6_next;
    // stage seven
    logic [17:0]   a7_reg, a7_next;
    logic [17:0]   doe7_reg;
    logic [EW-1:0] era7_reg;
    logic [2:0]    wd7_reg;
    // stage eight
    logic [8:0]    yoe8_reg, yoe8_next;
    logic [17:0]   doe8_reg;
    logic [EW-1:0] era8_reg;
    logic [2:0]    wd8_reg;
    // stage nine
    logic [8:0]    doy9_reg, doy9_next;
    logic          leap9_reg, leap9_next;
    logic [15:0]   ybase9_reg, ybase9_next;
    logic [2:0]    wd9_reg;
    // stage ten
    logic [3:0]    mp10_reg, mp10_next;
    logic [8:0]    doy10_reg;
    logic          leap10_reg;
    logic [15:0]   ybase10_reg;
    logic [2:0]    wd10_reg;
    // stage eleven
    e2c_date_t     date_reg, date_next;

    logic [ZP-1:0] era_prod, wk_prod;
    logic [35:0]   em;
    logic [2:0]    wraw;
    logic [3:0]    w3;
    logic [36:0]   p1460, p36524, p365;
    logic [18:0]   p100;
    logic [1:0]    c100;
    logic [8:0]    c100x;
    logic [17:0]   base;
    logic [31:0]   era400;
    logic [10:0]   x153;
    logic [22:0]   p153;
    logic [8:0]    start;
    logic          late;

    always_comb
    begin
        era_prod = ZP'(day.zz) * ZP'(M_ERA);
        wk_prod  = ZP'(day.zz) * ZP'(M7);

        // day of era; weekday is (zz + 3) mod 7 since eras hold whole weeks
        em        = 36'(era5_reg) * 36'd146097;
        doe6_next = zz5_reg - em[17:0];
        wraw      = zz5_reg[2:0] + wq5_reg;
        w3        = {1'b0, wraw} + 4'd3;
        wd6_next  = (w3 >= 4'd7) ? 3'(w3 - 4'd7) : w3[2:0];

        // leap day corrections ahead of the divide by 365
        p1460   = 37'(doe6_reg) * 37'(M1460);
        p36524  = 37'(doe6_reg) * 37'(M36524);
        a7_next = doe6_reg - 18'(p1460[29 +: 7]) + 18'(p36524[34 +: 3])
                  - 18'(doe6_reg == LAST_DAY_OF_ERA);

        p365      = 37'(a7_reg) * 37'(M365);
        yoe8_next = p365[27 +: 9];

        p100        = 19'(yoe8_reg) * 19'(M100);
        c100        = p100[16 +: 2];
        c100x       = 9'(c100) * 9'd100;
        leap9_next  = (yoe8_reg[1:0] == 2'd0) && ((yoe8_reg != c100x) || (yoe8_reg == 9'd0));
        base        = 18'(yoe8_reg) * 18'd365 + 18'(yoe8_reg[8:2]) - 18'(c100);
        doy9_next   = 9'(doe8_reg - base);
        era400      = 32'(era8_reg) * 32'd400;
        ybase9_next = 16'(yoe8_reg) + era400[15:0] - YEAR_OFFSET;

        x153      = 11'(doy9_reg) * 11'd5 + 11'd2;
        p153      = 23'(x153) * 23'(M153);
        mp10_next = p153[19 +: 4];

        // march based month back to january based, january and february roll the year
        start  = month_start(mp10_reg);
        late   = (mp10_reg >= FIRST_JAN_MP);
        date_next.dom     = 5'(doy10_reg - start + 9'd1);
        date_next.month   = late ? (mp10_reg - 4'd10) : (mp10_reg + 4'd2);
        date_next.yday    = late ? (doy10_reg - 9'd306)
                                 : (doy10_reg + 9'd59 + 9'(leap10_reg));
        date_next.years   = ybase10_reg + 16'(late);
        date_next.weekday = wd10_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            era5_reg    <= era_prod[S_ERA +: EW];
            wq5_reg     <= wk_prod[S7 +: 3];
            zz5_reg     <= day.zz[17:0];

            doe6_reg    <= doe6_next;
            era6_reg    <= era5_reg;
            wd6_reg     <= wd6_next;

            a7_reg      <= a7_next;
            doe7_reg    <= doe6_reg;
            era7_reg    <= era6_reg;
            wd7_reg     <= wd6_reg;

            yoe8_reg    <= yoe8_next;
            doe8_reg    <= doe7_reg;
            era8_reg    <= era7_reg;
            wd8_reg     <= wd7_reg;

            doy9_reg    <= doy9_next;
            leap9_reg   <= leap9_next;
            ybase9_reg  <= ybase9_next;
            wd9_reg     <= wd8_reg;

            mp10_reg    <= mp10_next;
            doy10_reg   <= doy9_reg;
            leap10_reg  <= leap9_reg;
            ybase10_reg <= ybase9_reg;
            wd10_reg    <= wd9_reg;

            date_reg    <= date_next;
        end
    end

    assign date = date_reg;

endmodule

[rtl/epoch_seconds_to_calendar_top.sv]
// top level: signed epoch seconds to broken-down utc calendar time
// throughput: one transfer per cycle unless stalled; all eleven register stages advance together
// stall: a held output freezes every stage, so s_tready drops while m_tvalid waits
// reset: rst_n is asynchronous and active low, it clears the stage valid bits only
module epoch_seconds_to_calendar_top
    import e2c_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // epoch_seconds, signed
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // second_of_minute, minute_of_hour, hour_of_day, weekday, years_since_1900,
    // day_of_year, month_index, day_of_month, zero pad
    output logic [OUT_W-1:0] m_tdata
);

    // one valid bit per stage, shifted in step with the data registers
    logic [PIPE_DEPTH-1:0] valid_reg, valid_next;
    logic                  advance;

    e2c_day_t  day;
    e2c_tod_t  tod;
    e2c_date_t date;

    // the whole pipe moves unless a finished result is waiting
    assign advance  = !valid_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = advance;
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = {valid_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stages one to four: day count and second of day
    e2c_day_split u_day_split
    (
        .clk           (clk),
        .en            (advance),
        .epoch_seconds (s_tdata[SECONDS_BITS-1:0]),
        .day           (day)
    );

    // stages five to eleven: time of day
    e2c_tod u_tod
    (
        .clk (clk),
        .en  (advance),
        .sod (day.sod),
        .tod (tod)
    );

    // stages five to eleven: calendar date and weekday
    e2c_civil u_civil
    (
        .clk  (clk),
        .en   (advance),
        .day  (day),
        .date (date)
    );

    // result fields packed from the lowest bit up
    assign m_tdata = {2'b00, date.dom, date.month, date.yday, date.years, date.weekday,
                      tod.hour, tod.minute, tod.second};

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while a result is held");

    a_field_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (tod.second < 6'd60) && (tod.minute < 6'd60) && (tod.hour < 5'd24)
                     && (date.weekday < 3'd7) && (date.month < 4'd12)
                     && (date.dom != 5'd0) && (date.yday < 9'd366))
        else $error("calendar field out of range");

    a_january_yday: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (date.month == 4'd0)) |-> (date.yday == 9'(date.dom) - 9'd1))
        else $error("day of year disagrees with day of month in january");

    a_february_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (date.month == 4'd1)) |-> (date.dom < 5'd30))
        else $error("february day beyond 29");
`endif

endmodule

[tb/sv/epoch_seconds_to_calendar_top_tb.sv]
// self-checking testbench for the epoch seconds to calendar pipeline
module epoch_seconds_to_calendar_top_tb
    import e2c_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // clocking and run control
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 4 * PIPE_DEPTH;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int RANDOM_PER_PHASE = 170;

    // calendar arithmetic
    localparam longint SECS_PER_DAY     = 86400;
    localparam longint DAYS_PER_ERA     = 146097;
    localparam longint EPOCH_SHIFT_DAYS = 719468;

    // bit offsets of the result fields in m_tdata, lowest first
    localparam int SEC_LSB  = 0;
    localparam int MIN_LSB  = 6;
    localparam int HOUR_LSB = 12;
    localparam int WDAY_LSB = 17;
    localparam int YEAR_LSB = 20;
    localparam int YDAY_LSB = 36;
    localparam int MON_LSB  = 45;
    localparam int MDAY_LSB = 49;
    localparam int PAD_LSB  = 54;

    typedef struct {
        longint      seconds;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [15:0] years;
        logic [8:0]  yday;
        logic [3:0]  month;
        logic [4:0]  mday;
    } calendar_t;

    // predicts the broken-down utc time of each accepted transfer and checks results
    class calendar_scoreboard;
        calendar_t expected_dates[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        // floor division into days, then civil date on 400 year eras starting march 1
        function calendar_t civil_time(longint secs);
            longint    days, sod, wd, z, era, doe, yoe, year, doy, mp, mon, yday;
            bit        is_leap;
            calendar_t c;
            days = secs / SECS_PER_DAY;
            sod  = secs % SECS_PER_DAY;
            if (sod < 0)
            begin
                sod  += SECS_PER_DAY;
                days -= 1;
            end
            // 1970-01-01 was a thursday
            wd = (days + 4) % 7;
            if (wd < 0)
                wd += 7;
            z    = days + EPOCH_SHIFT_DAYS;
            era  = (z >= 0 ? z : z - (DAYS_PER_ERA - 1)) / DAYS_PER_ERA;
            doe  = z - era * DAYS_PER_ERA;
            yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            year = yoe + era * 400;
            doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp   = (5 * doy + 2) / 153;
            // march based month: january and february belong to the next year
            if (mp < 10)
                mon = mp + 2;
            else
            begin
                mon  = mp - 10;
                year += 1;
            end
            is_leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
            if (mp < 10)
                yday = doy + 59 + (is_leap ? 1 : 0);
            else
                yday = doy - 306;
            c.seconds = secs;
            c.second  = 6'(sod % 60);
            c.minute  = 6'((sod / 60) % 60);
            c.hour    = 5'(sod / 3600);
            c.weekday = 3'(wd);
            c.years   = 16'(year - 1900);
            c.yday    = 9'(yday);
            c.month   = 4'(mon);
            c.mday    = 5'(doy - (153 * mp + 2) / 5 + 1);
            return c;
        endfunction

        function void note_seconds(logic [IN_W-1:0] word);
            longint secs;
            // only the low SECONDS_BITS count, read as two's complement
            secs = longint'($signed(word[SECONDS_BITS-1:0]));
            expected_dates.push_back(civil_time(secs));
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        task compare_field(string name, longint got, longint want, longint secs);
            if (got != want)
                report_mismatch($sformatf("%s for seconds %0d: got %0d, expected %0d",
                                          name, secs, got, want));
        endtask

        task check_calendar(logic [OUT_W-1:0] word);
            calendar_t want;
            if (expected_dates.size() == 0)
            begin
                report_mismatch($sformatf("result transfer with nothing pending: %h", word));
                return;
            end
            want = expected_dates.pop_front();
            if ($isunknown(word))
                report_mismatch($sformatf("unknown bits in result %h for seconds %0d",
                                          word, want.seconds));
            compare_field("second", longint'(word[SEC_LSB +: 6]), longint'(want.second),
                          want.seconds);
            compare_field("minute", longint'(word[MIN_LSB +: 6]), longint'(want.minute),
                          want.seconds);
            compare_field("hour", longint'(word[HOUR_LSB +: 5]), longint'(want.hour),
                          want.seconds);
            compare_field("weekday", longint'(word[WDAY_LSB +: 3]), longint'(want.weekday),
                          want.seconds);
            compare_field("years", longint'($signed(word[YEAR_LSB +: 16])),
                          longint'($signed(want.years)), want.seconds);
            compare_field("yday", longint'(word[YDAY_LSB +: 9]), longint'(want.yday),
                          want.seconds);
            compare_field("month", longint'(word[MON_LSB +: 4]), longint'(want.month),
                          want.seconds);
            compare_field("mday", longint'(word[MDAY_LSB +: 5]), longint'(want.mday),
                          want.seconds);
            compare_field("pad", longint'(word[OUT_W-1:PAD_LSB]), longint'(0), want.seconds);
        endtask
    endclass

    logic             clk      = 1'b1;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // idle rates in percent for the two sides, and the long output hold-off
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    logic hold_go    = 1'b0;
    int  hold_left   = 0;
    int  cycle_count = 0;

    calendar_scoreboard sb = new();

    // a few dates worth hitting on purpose: epoch, day edges, leap days including the
    // 400 year leap, non-leap centuries, era start, year zero, input extremes, the
    // 32 bit rollover and alternating bit patterns
    longint directed_secs [23] = '{
        64'sd0, -64'sd1, 64'sd86399, 64'sd86400, -64'sd86400, -64'sd86401,
        64'sd951782400, 64'sd951868799, 64'sd951868800, 64'sd978220800,
        -64'sd2203977600, -64'sd2203891200, 64'sd4107456000, 64'sd4107542400,
        -64'sd62162035200, -64'sd62162035201, -64'sd62167219200,
        64'sd549755813887, -64'sd549755813888,
        64'sd2147483647, 64'sd2147483648,
        64'sd366503875925, -64'sd366503875926
    };

    epoch_seconds_to_calendar_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // transfers are seen at the edge with pre-edge values, so ordering is safe
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_seconds(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_calendar(m_tdata);
    end

    // receiver: random backpressure, or a long hold-off counted here once requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_go)
        begin
            m_tready  <= 1'b0;
            hold_left <= RX_HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // offers one transfer, with random idle cycles ahead of it, and waits for acceptance
    task automatic send_seconds(input logic [IN_W-1:0] word);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // full range values, times within a few centuries of 1970, day edges and the extremes
    function automatic logic [IN_W-1:0] random_seconds();
        logic [63:0] bits;
        longint      v;
        longint      top;
        bits = {$urandom, $urandom};
        top  = longint'(1) <<< (SECONDS_BITS - 1);
        case ($urandom_range(3))
            0:       v = longint'(bits);
            1:       v = $signed(bits) >>> 30;
            2:       v = ($signed(bits) >>> 42) * SECS_PER_DAY
                         + longint'(int'($urandom_range(4))) - 2;
            default: v = bits[63] ? -top + longint'(bits[7:0])
                                  : top - 1 - longint'(bits[7:0]);
        endcase
        return IN_W'(v);
    endfunction

    // lowers valid and asks the receiver for its long hold-off
    task automatic request_hold_off();
        s_tvalid <= 1'b0;
        hold_go  <= 1'b1;
        @(posedge clk);
        hold_go  <= 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: sender idles lightly, receiver heavily
        tx_idle_pct <= 20;
        rx_idle_pct <= 71;
        foreach (directed_secs[i])
            send_seconds(IN_W'(directed_secs[i]));
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            if (n == RANDOM_PER_PHASE / 2)
                request_hold_off();
            send_seconds(random_seconds());
        end

        // sender pause until the pipeline has fully drained
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);

        // phase 2: roles swapped
        tx_idle_pct <= 71;
        rx_idle_pct <= 20;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_seconds(random_seconds());

        // phase 3: no idling, starting with a hold-off while the sender keeps offering
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        request_hold_off();
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_seconds(random_seconds());
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[epoch_seconds_to_calendar_top.f]
rtl/e2c_pkg.sv
rtl/e2c_day_split.sv
rtl/e2c_tod.sv
rtl/e2c_civil.sv
rtl/epoch_seconds_to_calendar_top.sv
tb/sv/epoch_seconds_to_calendar_top_tb.sv
